// File: sv/plm_pkg.sv
// Shared types, constants and helper functions of the piecewise-linear color map.
`timescale 1ns / 1ps

package plm_pkg;

   localparam int IN_W          = 16;
   localparam int POS_W         = 17;
   localparam int POS_LSB       = 24;
   localparam int CHAN_W        = 8;
   localparam int NUM_CHAN      = 3;
   localparam int STOP_W        = 41;
   localparam int NUM_STOP_REGS = 6;
   localparam int STOP_IDX_W    = 3;
   localparam int CNT_W         = 3;
   localparam int XC_W          = 9;
   localparam int LEVEL_SHIFT   = 8;
   localparam int PROD_W        = POS_W + CHAN_W;
   localparam int Q_BITS        = 8;
   localparam int STAGES        = 5 + Q_BITS;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int REG_IDX_W     = 3;

   localparam logic [XC_W-1:0] FULL_SCALE = 9'd256;

   // Register indexes of the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_NONE       = 3'd7;

   localparam logic [NUM_STOP_REGS-1:0][STOP_W-1:0] STOP_RESET = {
      41'd1099528339456, 41'd879629434624, 41'd659713752832,
      41'd439798005759,  41'd219898970367, 41'd128
   };

   typedef struct packed {
      logic [CNT_W-1:0]                       stop_count;
      logic [NUM_STOP_REGS-1:0][STOP_W-1:0]   stops;
   } cfg_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [POS_W-1:0]  dl_mag;
      logic              dl_neg;
      logic [POS_W-1:0]  den_mag;
      logic              den_neg;
      logic              bypass;
      logic [CHAN_W-1:0] c1;
      logic [CHAN_W-1:0] dc_mag;
      logic              dc_neg;
   } chan_terms_type;

   function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] s);
      return s[POS_LSB +: POS_W];
   endfunction

   // Channel 0 is red (bits 23:16), channel 2 is blue (bits 7:0).
   function automatic logic [CHAN_W-1:0] stop_color(input logic [STOP_W-1:0] s, input int ch);
      return s[(NUM_CHAN-1-ch)*CHAN_W +: CHAN_W];
   endfunction

endpackage

// File: sv/plm_csr.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module plm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [plm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [plm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [plm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output plm_pkg::cfg_type                  cfg
);

   logic [plm_pkg::REG_IDX_W-1:0]  reg_idx;
   logic [plm_pkg::STOP_IDX_W-1:0] stop_sel;
   logic                           wr_en;
   plm_pkg::cfg_type               cfg_ff;
   plm_pkg::cfg_type               cfg_in;

   assign reg_idx    = csr_paddr[plm_pkg::CSR_ADDR_W-1 -: plm_pkg::REG_IDX_W];
   assign stop_sel   = reg_idx - plm_pkg::STOP_IDX_W'(1);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            plm_pkg::REG_STOP_COUNT: cfg_in.stop_count = csr_pwdata[plm_pkg::CNT_W-1:0];
            plm_pkg::REG_NONE: ;
            default: cfg_in.stops[stop_sel] = csr_pwdata[plm_pkg::STOP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_count <= plm_pkg::CNT_W'(plm_pkg::NUM_STOP_REGS);
         cfg_ff.stops      <= plm_pkg::STOP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         plm_pkg::REG_STOP_COUNT: csr_prdata = plm_pkg::CSR_DATA_W'(cfg_ff.stop_count);
         plm_pkg::REG_NONE:       csr_prdata = '0;
         default: csr_prdata = plm_pkg::CSR_DATA_W'(cfg_ff.stops[stop_sel]);
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/plm_select.sv
// Stop search and difference terms: the first two pipeline stages.
`timescale 1ns / 1ps

module plm_select #(
   parameter int MAX_STOPS = 6
) (
   input  logic                                       clock,
   input  plm_pkg::pipe_ctrl_type                     ctrl,
   input  plm_pkg::cfg_type                           cfg,
   input  logic [plm_pkg::IN_W-1:0]                   intensity,
   output plm_pkg::chan_terms_type [plm_pkg::NUM_CHAN-1:0] terms
);

   localparam int LEVEL_W = plm_pkg::XC_W + plm_pkg::LEVEL_SHIFT;

   logic [plm_pkg::XC_W-1:0]        xc;
   logic [LEVEL_W-1:0]              level;
   logic [plm_pkg::CNT_W-1:0]       n;
   logic [plm_pkg::STOP_IDX_W-1:0]  lo_idx;
   logic [plm_pkg::STOP_IDX_W-1:0]  hi_idx;
   logic                            found;

   logic [LEVEL_W-1:0]              level_ff;
   logic [plm_pkg::STOP_W-1:0]      lo_ff;
   logic [plm_pkg::STOP_W-1:0]      hi_ff;
   logic                            found_ff;
   logic [LEVEL_W-1:0]              level_in;
   logic [plm_pkg::STOP_W-1:0]      lo_in;
   logic [plm_pkg::STOP_W-1:0]      hi_in;
   logic                            found_in;

   logic [plm_pkg::POS_W:0]         dl;
   logic [plm_pkg::POS_W:0]         den;
   plm_pkg::chan_terms_type [plm_pkg::NUM_CHAN-1:0] terms_ff;
   plm_pkg::chan_terms_type [plm_pkg::NUM_CHAN-1:0] terms_in;

   // Stage 0: clamp the sample, then look for the first stop at or above the level.
   always_comb begin
      xc    = (intensity > plm_pkg::IN_W'(plm_pkg::FULL_SCALE)) ? plm_pkg::FULL_SCALE
                                                               : intensity[plm_pkg::XC_W-1:0];
      level = {xc, {plm_pkg::LEVEL_SHIFT{1'b0}}};

      if (cfg.stop_count == '0) begin
         n = plm_pkg::CNT_W'(1);
      end else if (cfg.stop_count > plm_pkg::CNT_W'(MAX_STOPS)) begin
         n = plm_pkg::CNT_W'(MAX_STOPS);
      end else begin
         n = cfg.stop_count;
      end

      lo_idx = plm_pkg::STOP_IDX_W'(n - plm_pkg::CNT_W'(1));
      hi_idx = lo_idx;
      found  = 1'b0;
      // Walking downward lets the lowest qualifying stop win.
      for (int i = MAX_STOPS - 1; i >= 1; i--) begin
         if ((plm_pkg::CNT_W'(i) < n) &&
             (level <= plm_pkg::stop_pos(cfg.stops[i]))) begin
            lo_idx = plm_pkg::STOP_IDX_W'(i - 1);
            hi_idx = plm_pkg::STOP_IDX_W'(i);
            found  = 1'b1;
         end
      end

      level_in = level;
      lo_in    = cfg.stops[lo_idx];
      hi_in    = cfg.stops[hi_idx];
      found_in = found;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         level_ff <= level_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         found_ff <= found_in;
      end
   end

   // Stage 1: signed differences, split into sign and magnitude.
   always_comb begin
      dl  = {1'b0, level_ff} - {1'b0, plm_pkg::stop_pos(lo_ff)};
      den = {1'b0, plm_pkg::stop_pos(hi_ff)} - {1'b0, plm_pkg::stop_pos(lo_ff)};
      for (int ch = 0; ch < plm_pkg::NUM_CHAN; ch++) begin
         logic [plm_pkg::CHAN_W:0] dc;
         dc = {1'b0, plm_pkg::stop_color(hi_ff, ch)} - {1'b0, plm_pkg::stop_color(lo_ff, ch)};
         terms_in[ch].dl_neg  = dl[plm_pkg::POS_W];
         terms_in[ch].dl_mag  = dl[plm_pkg::POS_W] ? plm_pkg::POS_W'(-dl)
                                                   : dl[plm_pkg::POS_W-1:0];
         terms_in[ch].den_neg = den[plm_pkg::POS_W];
         terms_in[ch].den_mag = den[plm_pkg::POS_W] ? plm_pkg::POS_W'(-den)
                                                    : den[plm_pkg::POS_W-1:0];
         terms_in[ch].bypass  = !found_ff || (den == '0);
         terms_in[ch].c1      = plm_pkg::stop_color(lo_ff, ch);
         terms_in[ch].dc_neg  = dc[plm_pkg::CHAN_W];
         terms_in[ch].dc_mag  = dc[plm_pkg::CHAN_W] ? plm_pkg::CHAN_W'(-dc)
                                                    : dc[plm_pkg::CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule

// File: sv/plm_interp.sv
// One color channel: product, pipelined floor division and clamping.
`timescale 1ns / 1ps

module plm_interp (
   input  logic                         clock,
   input  plm_pkg::pipe_ctrl_type       ctrl,
   input  plm_pkg::chan_terms_type      terms,
   output logic [plm_pkg::CHAN_W-1:0]   color
);

   localparam int QM_W  = plm_pkg::Q_BITS + 2;
   localparam int SUM_W = QM_W + 1;
   localparam int DIV0  = 3;

   // Stage 2 registers.
   logic [plm_pkg::PROD_W-1:0]  prod_ff;
   logic [plm_pkg::POS_W-1:0]   den2_ff;
   logic                        neg2_ff;
   logic                        byp2_ff;
   logic [plm_pkg::CHAN_W-1:0]  c1_2_ff;
   logic [plm_pkg::PROD_W-1:0]  prod_in;
   logic                        neg2_in;

   // Entry 0 is the saturation stage; entries 1.. are the quotient steps.
   logic [plm_pkg::PROD_W-1:0]  rem_ff [plm_pkg::Q_BITS+1];
   logic [plm_pkg::Q_BITS-1:0]  q_ff   [plm_pkg::Q_BITS+1];
   logic [plm_pkg::POS_W-1:0]   den_ff [plm_pkg::Q_BITS+1];
   logic                        neg_ff [plm_pkg::Q_BITS+1];
   logic                        sat_ff [plm_pkg::Q_BITS+1];
   logic                        byp_ff [plm_pkg::Q_BITS+1];
   logic [plm_pkg::CHAN_W-1:0]  c1_ff  [plm_pkg::Q_BITS+1];
   logic [plm_pkg::PROD_W-1:0]  rem_in [plm_pkg::Q_BITS+1];
   logic [plm_pkg::Q_BITS-1:0]  q_in   [plm_pkg::Q_BITS+1];
   logic                        sat_in;

   logic [QM_W-1:0]             qmag;
   logic [SUM_W-1:0]            qsgn;
   logic [SUM_W-1:0]            sum;
   logic [plm_pkg::CHAN_W-1:0]  color_ff;
   logic [plm_pkg::CHAN_W-1:0]  color_in;

   // Both factors are widened first so the product keeps all of its bits.
   assign prod_in = {{plm_pkg::CHAN_W{1'b0}}, terms.dl_mag} *
                    {{plm_pkg::POS_W{1'b0}}, terms.dc_mag};
   assign neg2_in = terms.dl_neg ^ terms.dc_neg ^ terms.den_neg;

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         prod_ff <= prod_in;
         den2_ff <= terms.den_mag;
         neg2_ff <= neg2_in;
         byp2_ff <= terms.bypass;
         c1_2_ff <= terms.c1;
      end
   end

   // A quotient at or above full range clamps the channel whatever its low bits.
   assign sat_in    = prod_ff >= {den2_ff, {plm_pkg::Q_BITS{1'b0}}};
   assign rem_in[0] = prod_ff;
   assign q_in[0]   = '0;

   always_ff @(posedge clock) begin
      if (ctrl.load[DIV0]) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         den_ff[0] <= den2_ff;
         neg_ff[0] <= neg2_ff;
         sat_ff[0] <= sat_in;
         byp_ff[0] <= byp2_ff;
         c1_ff[0]  <= c1_2_ff;
      end
   end

   for (genvar s = 1; s <= plm_pkg::Q_BITS; s++) begin : g_step
      localparam int K = plm_pkg::Q_BITS - s;
      logic [plm_pkg::PROD_W:0] trial;

      always_comb begin
         trial     = {1'b0, rem_ff[s-1]} -
                     {1'b0, plm_pkg::PROD_W'(den_ff[s-1]) << K};
         rem_in[s] = rem_ff[s-1];
         q_in[s]   = q_ff[s-1];
         if (!trial[plm_pkg::PROD_W]) begin
            rem_in[s]  = trial[plm_pkg::PROD_W-1:0];
            q_in[s][K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.load[DIV0 + s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            den_ff[s] <= den_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
            byp_ff[s] <= byp_ff[s-1];
            c1_ff[s]  <= c1_ff[s-1];
         end
      end
   end

   // A negative quotient with a remainder rounds one further down.
   always_comb begin
      if (sat_ff[plm_pkg::Q_BITS]) begin
         qmag = QM_W'(1) << plm_pkg::Q_BITS;
      end else begin
         qmag = QM_W'(q_ff[plm_pkg::Q_BITS]) +
                QM_W'(neg_ff[plm_pkg::Q_BITS] && (rem_ff[plm_pkg::Q_BITS] != '0));
      end
      qsgn = neg_ff[plm_pkg::Q_BITS] ? SUM_W'(-{1'b0, qmag}) : {1'b0, qmag};
      sum  = SUM_W'(c1_ff[plm_pkg::Q_BITS]) + qsgn;
      if (byp_ff[plm_pkg::Q_BITS]) begin
         color_in = c1_ff[plm_pkg::Q_BITS];
      end else if (sum[SUM_W-1]) begin
         color_in = '0;
      end else if (sum[SUM_W-2:plm_pkg::CHAN_W] != '0) begin
         color_in = '1;
      end else begin
         color_in = sum[plm_pkg::CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[plm_pkg::STAGES-1]) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

// File: sv/piecewise_linear_colormap.sv
// Top level of the piecewise-linear color map: stream ports, pipeline control, registers.
// Throughput is one item per clock unless the result port stalls; the eight quotient
// stages set the pipeline depth. Each stage holds its item only while it and every
// later stage are full and the output is stalled, so bubbles close up under stall.
// Synchronous reset empties the pipeline and loads the six default color stops.
`timescale 1ns / 1ps

module piecewise_linear_colormap #(
   parameter int MAX_STOPS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input items.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,    // [15:0] intensity
   // Result items.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,    // [7:0] red, [15:8] green, [23:16] blue
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [plm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [plm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [plm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int LAST = plm_pkg::STAGES - 1;

   plm_pkg::cfg_type                                cfg;
   plm_pkg::pipe_ctrl_type                          ctrl;
   plm_pkg::chan_terms_type [plm_pkg::NUM_CHAN-1:0] terms;
   logic [plm_pkg::NUM_CHAN-1:0][plm_pkg::CHAN_W-1:0] colors;

   logic [plm_pkg::STAGES-1:0] valid_ff;
   logic [plm_pkg::STAGES-1:0] valid_in;
   logic [plm_pkg::STAGES-1:0] ready;

   plm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // A stage may load when it or some stage after it up to the output is empty, or when
   // the output is being taken. Equivalently, it may load when the result port is ready
   // or some stage at or after it is empty.
   always_comb begin
      for (int k = 0; k < plm_pkg::STAGES; k++) begin
         logic [plm_pkg::STAGES-1:0] upper;
         upper    = {plm_pkg::STAGES{1'b1}} << k;
         ready[k] = rsp_tready || !(&(valid_ff | ~upper));
      end
      valid_in = {valid_ff[plm_pkg::STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < plm_pkg::STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign ctrl.load  = ready;
   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[LAST];

   // Stages 0 and 1: stop search and signed difference terms.
   plm_select #(
      .MAX_STOPS (MAX_STOPS)
   ) u_select (
      .clock     (clock),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .intensity (req_tdata[plm_pkg::IN_W-1:0]),
      .terms     (terms)
   );

   // Stages 2 through 12: one product, divider and clamp per channel.
   for (genvar ch = 0; ch < plm_pkg::NUM_CHAN; ch++) begin : g_chan
      plm_interp u_interp (
         .clock (clock),
         .ctrl  (ctrl),
         .terms (terms[ch]),
         .color (colors[ch])
      );
   end

   // Red sits in the lowest byte.
   assign rsp_tdata = {colors[2], colors[1], colors[0]};

`ifndef ASSERT_OFF
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted item did not enter the first stage");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("input accepted while every stage is full and output stalled");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[LAST] |-> req_tready)
      else $error("input refused while the output stage is empty");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");
`endif

endmodule

// File: test/colormap_checker.sv
// Scoreboard for the color map: tracks register writes, predicts each color and compares.
`timescale 1ns / 1ps

module colormap_checker #(
   parameter int MAX_STOPS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [15:0]                       req_tdata,    // [15:0] intensity
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [23:0]                       rsp_tdata,    // [7:0] red, [15:8] green, [23:16] blue
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [plm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [plm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                              csr_pready,
   output int                                error_count,
   output int                                pending_count
);

   typedef struct {
      logic [15:0] intensity;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } color_entry_type;

   logic [plm_pkg::CNT_W-1:0]  palette_count;
   logic [plm_pkg::STOP_W-1:0] palette [plm_pkg::NUM_STOP_REGS];
   color_entry_type            color_queue [$];
   int                         report_count;

   initial begin
      error_count   = 0;
      pending_count = 0;
      report_count  = 0;
   end

   // Quotient rounded toward minus infinity, for either sign of the divisor.
   function automatic longint floor_quot(input longint num, input longint den);
      longint q;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic logic [7:0] blend(input logic [plm_pkg::STOP_W-1:0] lo,
                                        input logic [plm_pkg::STOP_W-1:0] hi,
                                        input longint level, input int shift);
      longint t1, t2, c1, c2, den, v;
      t1  = longint'(lo[plm_pkg::POS_LSB +: plm_pkg::POS_W]);
      t2  = longint'(hi[plm_pkg::POS_LSB +: plm_pkg::POS_W]);
      c1  = longint'(lo[shift +: 8]);
      c2  = longint'(hi[shift +: 8]);
      den = t2 - t1;
      v   = c1;
      // Coincident stops give no slope, so the lower color holds.
      if (den != 0) v = c1 + floor_quot((level - t1) * (c2 - c1), den);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic color_entry_type predict_color(input logic [15:0] intensity);
      color_entry_type            c;
      longint                     level;
      int                         used;
      logic [plm_pkg::STOP_W-1:0] lo, hi;
      bit                         found;
      level = (intensity > 16'd256) ? 64'sd65536 : longint'(intensity) * 256;
      used  = int'(palette_count);
      if (used < 1) used = 1;
      if (used > MAX_STOPS) used = MAX_STOPS;
      lo    = palette[used-1];
      hi    = lo;
      found = 1'b0;
      for (int i = 1; i < used; i++) begin
         if (!found && level <= longint'(palette[i][plm_pkg::POS_LSB +: plm_pkg::POS_W])) begin
            lo    = palette[i-1];
            hi    = palette[i];
            found = 1'b1;
         end
      end
      c.intensity = intensity;
      if (found) begin
         c.red   = blend(lo, hi, level, 16);
         c.green = blend(lo, hi, level, 8);
         c.blue  = blend(lo, hi, level, 0);
      end else begin
         c.red   = lo[23:16];
         c.green = lo[15:8];
         c.blue  = lo[7:0];
      end
      return c;
   endfunction

   always @(posedge clock) begin : monitor
      logic [plm_pkg::REG_IDX_W-1:0] reg_idx;
      color_entry_type               want;
      logic [7:0]                    got_red, got_green, got_blue;
      if (reset) begin
         palette_count = 3'd6;
         palette[0]    = 41'd128;
         palette[1]    = 41'd219898970367;
         palette[2]    = 41'd439798005759;
         palette[3]    = 41'd659713752832;
         palette[4]    = 41'd879629434624;
         palette[5]    = 41'd1099528339456;
         color_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            reg_idx = csr_paddr[plm_pkg::CSR_ADDR_W-1:3];
            if (reg_idx == plm_pkg::REG_STOP_COUNT)
               palette_count = csr_pwdata[plm_pkg::CNT_W-1:0];
            // Stop registers follow the count register; the top index is unmapped.
            else if (reg_idx != plm_pkg::REG_NONE)
               palette[reg_idx-1] = csr_pwdata[plm_pkg::STOP_W-1:0];
         end
         if (req_tvalid && req_tready) color_queue.push_back(predict_color(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got_red   = rsp_tdata[7:0];
            got_green = rsp_tdata[15:8];
            got_blue  = rsp_tdata[23:16];
            if (color_queue.size() == 0) begin
               error_count++;
               if (report_count < 10)
                  $display("%0t: result r=%0d g=%0d b=%0d with no item outstanding",
                           $realtime, got_red, got_green, got_blue);
               report_count++;
            end else begin
               want = color_queue.pop_front();
               if (got_red !== want.red || got_green !== want.green || got_blue !== want.blue) begin
                  error_count++;
                  if (report_count < 10)
                     $display("%0t: intensity %0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                              $realtime, want.intensity, want.red, want.green, want.blue,
                              got_red, got_green, got_blue);
                  report_count++;
               end
            end
         end
      end
      pending_count = color_queue.size();
   end

endmodule

// File: test/testbench.sv
// Top of the color map testbench: clock, reset, stimulus, register programming and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_STOPS = 6;
   // Stop registers sit directly above the count register.
   localparam logic [plm_pkg::REG_IDX_W-1:0] REG_FIRST_STOP = plm_pkg::REG_STOP_COUNT + 3'd1;

   typedef enum {PALETTE_SORTED, PALETTE_TIED, PALETTE_SHUFFLED, PALETTE_WIDE} palette_style_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [15:0]                      req_tdata;    // [15:0] intensity
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [23:0]                      rsp_tdata;    // [7:0] red, [15:8] green, [23:16] blue
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [plm_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [plm_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [plm_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   int error_count;
   int pending_count;
   // Percent chance of a gap before each item and of a stall on each result cycle.
   int gap_pct;
   int stall_pct;

   piecewise_linear_colormap #(
      .MAX_STOPS(MAX_STOPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   colormap_checker #(
      .MAX_STOPS(MAX_STOPS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .error_count(error_count),
      .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The result side decides at every falling edge whether it takes an item in the next cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Build a stop register image from a position and a color.
   function automatic logic [plm_pkg::CSR_DATA_W-1:0] pack_stop(input logic [16:0] pos,
                                                               input logic [7:0] r,
                                                               input logic [7:0] g,
                                                               input logic [7:0] b);
      return plm_pkg::CSR_DATA_W'({pos, r, g, b});
   endfunction

   // Register index of stop k.
   function automatic logic [plm_pkg::REG_IDX_W-1:0] stop_reg(input int k);
      return plm_pkg::REG_IDX_W'(int'(REG_FIRST_STOP) + k);
   endfunction

   // A color byte that lands on the rails about half the time.
   function automatic logic [7:0] shade();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Two-phase register write. Called and returns at a falling edge.
   task automatic csr_write(input logic [plm_pkg::REG_IDX_W-1:0] idx,
                            input logic [plm_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Present one item and hold it until the block takes it. The valid line is left high on
   // return so that back-to-back items never lower and raise it within one time step.
   task automatic send_intensity(input logic [15:0] value);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding color to come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [15:0]               probes [13];
      logic [16:0]               pos [plm_pkg::NUM_STOP_REGS];
      logic [16:0]               held;
      logic [plm_pkg::CNT_W-1:0] count;
      palette_style_type         style;
      idle_mode_type             mode;
      int                        pick;

      probes      = '{16'd0, 16'd1, 16'd51, 16'd52, 16'd128, 16'd255, 16'd256,
                      16'd257, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      gap_pct     = 0;
      stall_pct   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default palette straight out of reset: both ends of the range, the points just
      // around a stop, the clamp at full scale and the extremes of the input field.
      foreach (probes[i]) send_intensity(probes[i]);
      drain();

      // Two stops at the same position: no slope, so the lower color is held up to it.
      // The unmapped register index is written too and must change nothing.
      csr_write(plm_pkg::REG_STOP_COUNT, 64'd2);
      csr_write(stop_reg(0), pack_stop(17'd32768, 8'd10, 8'd20, 8'd30));
      csr_write(stop_reg(1), pack_stop(17'd32768, 8'd200, 8'd100, 8'd0));
      csr_write(stop_reg(2), pack_stop(17'd50000, 8'd1, 8'd2, 8'd3));
      csr_write(stop_reg(3), pack_stop(17'd60000, 8'd255, 8'd0, 8'd255));
      csr_write(stop_reg(4), pack_stop(17'd62000, 8'd0, 8'd255, 8'd0));
      csr_write(stop_reg(5), pack_stop(17'd65536, 8'd255, 8'd255, 8'd255));
      csr_write(plm_pkg::REG_NONE, {plm_pkg::CSR_DATA_W{1'b1}});
      send_intensity(16'd128);
      send_intensity(16'd0);
      send_intensity(16'd256);
      drain();

      // Stops out of order: the first segment runs backward, with a negative divisor.
      csr_write(plm_pkg::REG_STOP_COUNT, 64'd3);
      csr_write(stop_reg(0), pack_stop(17'd40000, 8'd0, 8'd255, 8'd0));
      csr_write(stop_reg(1), pack_stop(17'd10000, 8'd255, 8'd0, 8'd255));
      csr_write(stop_reg(2), pack_stop(17'd65536, 8'd0, 8'd0, 8'd0));
      send_intensity(16'd20);
      send_intensity(16'd100);
      send_intensity(16'd256);
      drain();

      // A count of zero behaves as a single stop, whose color is returned everywhere.
      csr_write(plm_pkg::REG_STOP_COUNT, 64'd0);
      send_intensity(16'd0);
      send_intensity(16'd256);
      drain();

      // A count of seven saturates to the full set; the last stop sits at the largest
      // position the field can hold, above full scale.
      csr_write(plm_pkg::REG_STOP_COUNT, 64'd7);
      csr_write(stop_reg(5), pack_stop(17'h1FFFF, 8'd255, 8'd255, 8'd255));
      send_intensity(16'd256);
      send_intensity(16'd200);
      drain();

      // Random part. Each round programs a fresh palette, streams samples under one of the
      // idling patterns and then drains; the drain also gives the required full pause.
      for (int round = 0; round < 12; round++) begin
         mode = idle_mode_type'(round % 4);
         case (mode)
            IDLE_NONE: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            IDLE_SENDER: begin
               gap_pct   = 80;
               stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               gap_pct   = 0;
               stall_pct = 80;
            end
            default: begin
               gap_pct   = 10;
               stall_pct = 10;
            end
         endcase

         pick  = $urandom_range(9);
         style = (pick < 6) ? PALETTE_SORTED : (pick < 8) ? PALETTE_TIED :
                 (pick == 8) ? PALETTE_SHUFFLED : PALETTE_WIDE;
         for (int k = 0; k < plm_pkg::NUM_STOP_REGS; k++)
            pos[k] = (style == PALETTE_WIDE) ? 17'($urandom_range(131071))
                                             : 17'($urandom_range(65536));
         if (style != PALETTE_SHUFFLED) begin
            for (int a = 0; a < plm_pkg::NUM_STOP_REGS - 1; a++) begin
               for (int b = 0; b < plm_pkg::NUM_STOP_REGS - 1 - a; b++) begin
                  if (pos[b] > pos[b+1]) begin
                     held     = pos[b];
                     pos[b]   = pos[b+1];
                     pos[b+1] = held;
                  end
               end
            end
         end
         if (style == PALETTE_TIED) begin
            for (int k = 1; k < plm_pkg::NUM_STOP_REGS; k++)
               if ($urandom_range(1)) pos[k] = pos[k-1];
         end
         // Pin the outer stops to the ends of the scale now and then.
         if (style == PALETTE_SORTED && $urandom_range(1)) begin
            pos[0]                          = 17'd0;
            pos[plm_pkg::NUM_STOP_REGS - 1] = 17'd65536;
         end

         pick = $urandom_range(9);
         case (pick)
            0:       count = 3'd0;
            1:       count = 3'd7;
            2:       count = 3'd1;
            default: count = 3'($urandom_range(2, 6));
         endcase
         csr_write(plm_pkg::REG_STOP_COUNT,
                   {{(plm_pkg::CSR_DATA_W - plm_pkg::CNT_W){1'b0}}, count});
         for (int k = 0; k < plm_pkg::NUM_STOP_REGS; k++)
            csr_write(stop_reg(k), pack_stop(pos[k], shade(), shade(), shade()));

         // Most samples fall inside the scale; the rest push past the clamp and
         // exercise every bit of the input field.
         for (int k = 0; k < 96; k++) begin
            case ($urandom_range(3))
               0, 1:    send_intensity(16'($urandom_range(256)));
               2:       send_intensity(16'($urandom_range(300)));
               default: send_intensity(16'($urandom_range(65535)));
            endcase
         end
         drain();
      end

      // Give a stray extra result time to show up before the verdict.
      gap_pct   = 0;
      stall_pct = 0;
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("PASS piecewise_linear_colormap");
      end else begin
         $display("FAIL piecewise_linear_colormap");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("FAIL piecewise_linear_colormap");
      $finish;
   end

endmodule
